[rtl/rsr_pkg.sv]
// running statistics reservoir: shared constants, types and state codes
// no dependencies
`default_nettype none
package rsr_pkg;
  localparam int RES_DEPTH = 128;
  localparam int SLOT_BITS = 7;
  localparam int COUNT_BITS = 24;
  localparam int SAMPLE_BITS = 16;
  localparam logic [7:0] DEFAULT_RES_SIZE = 8'd100;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  // unused code, behaves as a query
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic signed [15:0] sample;
    logic [31:0] rand_fraction;
    logic [6:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [23:0] count;
    logic signed [31:0] mean;
    logic [46:0] variance;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic        mean_valid;
    logic        variance_valid;
    logic        count_full;
    logic signed [15:0] slot_value;
    logic        slot_valid;
    logic        sample_kept;
    logic [6:0]  kept_slot;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MDIV, ST_MUPD, ST_MUL, ST_ACC, ST_RND, ST_VDIV, ST_VFIN, ST_RD, ST_OUT
  } state_t;
endpackage
`default_nettype wire

[rtl/rsr_stream_if.sv]
// valid/ready channel carrying one payload type
// depends on rsr_pkg for payload types
`default_nettype none
interface rsr_in_if;
  logic valid;
  logic ready;
  rsr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsr_out_if;
  logic valid;
  logic ready;
  rsr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsr_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/rsr_sdiv.sv]
// bit-serial restoring divider, one quotient bit per cycle, 64/64 unsigned
// depends on nothing else
`default_nettype none
module rsr_sdiv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient,
  output logic [63:0]      remainder
);
  logic [63:0] q_r, q_nxt, rem_r, rem_nxt, d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [65:0] trial;

  always_comb begin
    trial = {1'b0, rem_r, q_r[63]} - {2'b0, d_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (!trial[65]) begin
        rem_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end

  assign busy = (cnt_r != '0);
  assign quotient = q_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

[rtl/rsr_smul.sv]
// shift-add multiplier, 32x32 unsigned, one multiplier bit per cycle
// depends on nothing else
`default_nettype none
module rsr_smul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             busy,
  output logic [63:0]      product
);
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] a_r, b_r, b_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] top;

  always_comb begin
    top = {1'b0, acc_r[63:32]} + (b_r[0] ? {1'b0, a_r} : 33'd0);
    acc_nxt = acc_r;
    b_nxt = b_r;
    cnt_nxt = cnt_r;
    if (start) begin
      acc_nxt = '0;
      b_nxt = b;
      cnt_nxt = 6'd32;
    end else if (cnt_r != '0) begin
      acc_nxt = {top, acc_r[31:1]};
      b_nxt = {1'b0, b_r[31:1]};
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r <= b_nxt;
    if (start) a_r <= a;
  end

  assign busy = (cnt_r != '0);
  assign product = acc_r;
endmodule
`default_nettype wire

[rtl/running_stats_reservoir.sv]
// running statistics with reservoir sampling, top level; depends on rsr_pkg,
// rsr_stream_if, rsr_sdiv and rsr_smul
// an add beat runs three serial divides and two serial multiplies; a query, clear or
// ignored add runs two serial divides, and either runs one divide fewer when variance
// saturates; one item at a time, next input beat the cycle after the result beat
// reset clears count, mean, m2, extremes and fill count; reservoir size back to 100
`default_nettype none
module running_stats_reservoir (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rsr_in_if.sink     in_ch,
  rsr_out_if.source  out_ch,
  rsr_cfg_if.sink    cfg_ch
);
  rsr_pkg::state_t st_r, st_nxt;
  rsr_pkg::in_item_t item_r;
  rsr_pkg::out_item_t res_r;
  logic out_valid_r;

  logic [7:0]  size_r;
  logic [23:0] cnt_r;
  logic signed [31:0] mean_r;
  logic [63:0] m2_r;
  logic signed [15:0] min_r, max_r;
  logic [7:0]  filled_r;
  logic signed [15:0] mem [rsr_pkg::RES_DEPTH];
  logic signed [15:0] rd_r;

  logic signed [48:0] delta_r;
  logic full_r, kept_r;
  logic [6:0] kslot_r;
  logic [46:0] var_r;
  logic [63:0] scratch_r;

  logic div_start, div_busy;
  logic mul_start, mul_busy;
  logic [63:0] dvd, dvs, quo, rem, prod;
  logic [31:0] ma, mb;
  logic phase_r;

  rsr_sdiv u_div (.clk, .rst_n, .start(div_start), .dividend(dvd), .divisor(dvs),
    .busy(div_busy), .quotient(quo), .remainder(rem));
  rsr_smul u_mul (.clk, .rst_n, .start(mul_start), .a(ma), .b(mb),
    .busy(mul_busy), .product(prod));

  logic [7:0] eff;
  assign eff = (size_r > 8'(rsr_pkg::RES_DEPTH)) ? 8'(rsr_pkg::RES_DEPTH) : size_r;

  logic [23:0] cnt_inc;
  assign cnt_inc = cnt_r + 24'd1;

  logic signed [48:0] xq, nm49, delta2;
  logic [48:0] abs_d, abs_d2, mag_q;
  logic signed [48:0] qsig;
  logic signed [31:0] nm;
  assign xq = 49'(signed'(item_r.sample)) <<< 16;
  assign abs_d = delta_r[48] ? 49'(-delta_r) : 49'(delta_r);
  assign mag_q = quo[48:0];
  assign qsig = delta_r[48] ? -signed'(mag_q) : signed'(mag_q);
  assign nm49 = 49'(mean_r) + qsig;
  assign nm = (nm49 > 49'sd2147483647) ? 32'sh7fffffff :
              (nm49 < -49'sd2147483648) ? 32'sh80000000 : nm49[31:0];
  assign delta2 = xq - 49'(mean_r);
  assign abs_d2 = delta2[48] ? 49'(-delta2) : 49'(delta2);

  // both magnitudes stay below 2^32, so the full product fits 64 bits
  logic [64:0] m2_sum;
  assign m2_sum = {1'b0, m2_r} + {25'd0, prod[63:24]};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rsr_pkg::ST_IDLE: if (in_ch.valid && !out_valid_r) begin
        if (in_ch.data.func == rsr_pkg::FUNC_ADD && cnt_r != 24'hffffff)
          st_nxt = rsr_pkg::ST_MDIV;
        else st_nxt = rsr_pkg::ST_VDIV;
      end
      rsr_pkg::ST_MDIV: if (phase_r && !div_busy) st_nxt = rsr_pkg::ST_MUPD;
      rsr_pkg::ST_MUPD: st_nxt = rsr_pkg::ST_MUL;
      rsr_pkg::ST_MUL:  if (phase_r && !mul_busy) st_nxt = rsr_pkg::ST_ACC;
      rsr_pkg::ST_ACC:  st_nxt = rsr_pkg::ST_RND;
      rsr_pkg::ST_RND:  if (phase_r && !mul_busy) st_nxt = rsr_pkg::ST_VDIV;
      rsr_pkg::ST_VDIV: if (phase_r && !div_busy) begin
        // saturated quotient needs no fraction pass
        if (quo >= 64'h80_0000_0000) st_nxt = rsr_pkg::ST_RD;
        else st_nxt = rsr_pkg::ST_VFIN;
      end
      rsr_pkg::ST_VFIN: if (phase_r && !div_busy) st_nxt = rsr_pkg::ST_RD;
      rsr_pkg::ST_RD:   st_nxt = rsr_pkg::ST_OUT;
      rsr_pkg::ST_OUT:  st_nxt = rsr_pkg::ST_IDLE;
      default: st_nxt = rsr_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared serial units
  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    dvd = '0;
    dvs = 64'd1;
    ma = '0;
    mb = '0;
    case (st_r)
      rsr_pkg::ST_MDIV: begin
        div_start = !phase_r;
        dvd = 64'(abs_d);
        dvs = 64'(cnt_r);
      end
      rsr_pkg::ST_MUL: begin
        mul_start = !phase_r;
        ma = abs_d[31:0];
        mb = abs_d2[31:0];
      end
      rsr_pkg::ST_RND: begin
        mul_start = !phase_r;
        ma = item_r.rand_fraction;
        mb = 32'(cnt_r);
      end
      rsr_pkg::ST_VDIV: begin
        div_start = !phase_r;
        dvd = m2_r;
        dvs = 64'(cnt_r - 24'd1);
      end
      rsr_pkg::ST_VFIN: begin
        div_start = !phase_r;
        dvd = {scratch_r[55:0], 8'd0};
        dvs = 64'(cnt_r - 24'd1);
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (st_r == rsr_pkg::ST_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rsr_pkg::ST_IDLE;
      phase_r <= 1'b0;
      out_valid_r <= 1'b0;
      size_r <= rsr_pkg::DEFAULT_RES_SIZE;
      cnt_r <= '0;
      mean_r <= '0;
      m2_r <= '0;
      min_r <= 16'sh7fff;
      max_r <= 16'sh8000;
      filled_r <= '0;
    end else begin
      st_r <= st_nxt;
      phase_r <= (st_nxt == st_r) && (st_r != rsr_pkg::ST_IDLE);
      if (cfg_ch.valid) size_r <= cfg_ch.data;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (st_r)
        rsr_pkg::ST_IDLE: if (in_ch.valid && !out_valid_r) begin
          item_r <= in_ch.data;
          full_r <= 1'b0;
          kept_r <= 1'b0;
          kslot_r <= '0;
          if (in_ch.data.func == rsr_pkg::FUNC_CLEAR) begin
            cnt_r <= '0;
            mean_r <= '0;
            m2_r <= '0;
            min_r <= 16'sh7fff;
            max_r <= 16'sh8000;
            filled_r <= '0;
          end else if (in_ch.data.func == rsr_pkg::FUNC_ADD) begin
            if (cnt_r == 24'hffffff) begin
              full_r <= 1'b1;
            end else begin
              cnt_r <= cnt_inc;
              delta_r <= (49'(signed'(in_ch.data.sample)) <<< 16) - 49'(mean_r);
            end
          end
        end
        rsr_pkg::ST_MUPD: begin
          mean_r <= nm;
          if (item_r.sample < min_r) min_r <= item_r.sample;
          if (item_r.sample > max_r) max_r <= item_r.sample;
        end
        rsr_pkg::ST_ACC: begin
          m2_r <= m2_sum[64] ? '1 : m2_sum[63:0];
        end
        rsr_pkg::ST_RND: if (phase_r && !mul_busy) begin
          if (filled_r < eff) begin
            kept_r <= 1'b1;
            kslot_r <= filled_r[6:0];
            mem[filled_r[6:0]] <= item_r.sample;
            filled_r <= filled_r + 8'd1;
          end else if (prod[63:32] < 32'(eff)) begin
            kept_r <= 1'b1;
            kslot_r <= prod[38:32];
            mem[prod[38:32]] <= item_r.sample;
          end
        end
        rsr_pkg::ST_VDIV: if (phase_r && !div_busy) begin
          scratch_r <= rem;
          var_r <= (quo >= 64'h80_0000_0000) ? '1 : 47'({quo[38:0], 8'd0});
        end
        rsr_pkg::ST_VFIN: if (phase_r && !div_busy) begin
          var_r <= var_r + quo[46:0];
        end
        rsr_pkg::ST_RD: begin
          rd_r <= mem[item_r.read_slot];
        end
        rsr_pkg::ST_OUT: begin
          out_valid_r <= 1'b1;
          res_r.count <= cnt_r;
          res_r.mean <= (cnt_r == '0) ? 32'sd0 : mean_r;
          res_r.variance <= (cnt_r < 24'd2) ? '0 : var_r;
          res_r.min_value <= min_r;
          res_r.max_value <= max_r;
          res_r.mean_valid <= (cnt_r != '0);
          res_r.variance_valid <= (cnt_r >= 24'd2);
          res_r.count_full <= full_r;
          res_r.slot_valid <= ({1'b0, item_r.read_slot} < filled_r);
          res_r.slot_value <= ({1'b0, item_r.read_slot} < filled_r) ? rd_r : 16'sd0;
          res_r.sample_kept <= kept_r;
          res_r.kept_slot <= kslot_r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench for running_stats_reservoir: a directed table, then random phases at several
// reservoir sizes, each result checked field by field against a built-in welford predictor
// or a fixed expected value; depends on rsr_pkg, rsr_stream_if and the block's rtl
`timescale 1ns / 100ps
module tb_top;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HOLD_CYCLES = 2000;
  localparam int HOLD_AT_BEAT = 700;
  localparam int DIR_ROWS = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rsr_in_if  in_ch();
  rsr_out_if out_ch();
  rsr_cfg_if cfg_ch();

  running_stats_reservoir dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int unsigned res_size;
  longint      stat_count;
  int          stat_mean;
  bit [63:0]   stat_m2;
  shortint     stat_min, stat_max;
  int unsigned slots_filled;
  shortint     slot_store [rsr_pkg::RES_DEPTH];

  rsr_pkg::out_item_t expected_results [$];
  int          errors = 0;
  int          in_beats = 0;
  bit          calm = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  function automatic void clear_stats();
    stat_count = 0;
    stat_mean = 0;
    stat_m2 = '0;
    stat_min = 16'sh7fff;
    stat_max = -16'sh8000;
    slots_filled = 0;
  endfunction

  function automatic rsr_pkg::out_item_t welford_step(rsr_pkg::in_item_t it);
    rsr_pkg::out_item_t r;
    longint x, xq, delta, delta2, nm;
    bit [127:0] a, b, p;
    bit [63:0] prod, d, q, rem, v, j;
    int unsigned eff;
    bit full, kept;
    int unsigned kslot;
    eff = (res_size > rsr_pkg::RES_DEPTH) ? rsr_pkg::RES_DEPTH : res_size;
    full = 1'b0;
    kept = 1'b0;
    kslot = 0;
    x = it.sample;
    if (it.func == rsr_pkg::FUNC_CLEAR) begin
      clear_stats();
    end else if (it.func == rsr_pkg::FUNC_ADD) begin
      if (stat_count >= (64'd1 << rsr_pkg::COUNT_BITS) - 1) begin
        full = 1'b1;
      end else begin
        xq = x * 65536;
        stat_count++;
        delta = xq - longint'(stat_mean);
        nm = longint'(stat_mean) + delta / stat_count;
        if (nm > 64'sd2147483647) nm = 64'sd2147483647;
        if (nm < -64'sd2147483648) nm = -64'sd2147483648;
        stat_mean = int'(nm);
        delta2 = xq - nm;
        a = (delta < 0) ? 128'(-delta) : 128'(delta);
        b = (delta2 < 0) ? 128'(-delta2) : 128'(delta2);
        p = a * b;
        prod = p[63:0] >> 24;
        if (stat_m2 > ~64'd0 - prod) stat_m2 = ~64'd0;
        else stat_m2 = stat_m2 + prod;
        if (x < stat_min) stat_min = shortint'(x);
        if (x > stat_max) stat_max = shortint'(x);
        if (slots_filled < eff) begin
          kslot = slots_filled;
          kept = 1'b1;
          slots_filled++;
        end else begin
          j = ({32'd0, it.rand_fraction} * 64'(stat_count)) >> 32;
          if (j < eff) begin
            kslot = int'(j);
            kept = 1'b1;
          end
        end
        if (kept) slot_store[kslot] = shortint'(x);
      end
    end
    v = '0;
    if (stat_count >= 2) begin
      d = 64'(stat_count - 1);
      q = stat_m2 / d;
      rem = stat_m2 % d;
      if (q >= (64'd1 << 39)) v = (64'd1 << 47) - 1;
      else begin
        v = (q << 8) + ((rem << 8) / d);
        if (v > (64'd1 << 47) - 1) v = (64'd1 << 47) - 1;
      end
    end
    r = '0;
    r.count = stat_count[23:0];
    r.mean = stat_mean;
    r.variance = v[46:0];
    r.min_value = stat_min;
    r.max_value = stat_max;
    r.mean_valid = (stat_count >= 1);
    r.variance_valid = (stat_count >= 2);
    r.count_full = full;
    r.slot_valid = (it.read_slot < slots_filled);
    r.slot_value = r.slot_valid ? slot_store[it.read_slot] : 16'sd0;
    r.sample_kept = kept;
    r.kept_slot = kept ? kslot[6:0] : 7'd0;
    return r;
  endfunction

  function automatic rsr_pkg::out_item_t fixed_result(int cnt, int mean, shortint mn,
                                                      shortint mx, shortint sv, bit svalid,
                                                      bit kept);
    rsr_pkg::out_item_t r;
    r = '0;
    r.count = cnt[23:0];
    r.mean = mean;
    r.min_value = mn;
    r.max_value = mx;
    r.mean_valid = (cnt >= 1);
    r.slot_value = sv;
    r.slot_valid = svalid;
    r.sample_kept = kept;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // sender: called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(rsr_pkg::in_item_t it, bit typed, rsr_pkg::out_item_t fixed);
    rsr_pkg::out_item_t r;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    r = welford_step(it);
    expected_results.insert(expected_results.size(), typed ? fixed : r);
    in_beats++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_size(logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    res_size = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic rsr_pkg::in_item_t random_item(int unsigned eff);
    rsr_pkg::in_item_t it;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 80) it.func = rsr_pkg::FUNC_ADD;
    else if (k < 92) it.func = rsr_pkg::FUNC_QUERY;
    else if (k < 95) it.func = rsr_pkg::FUNC_CLEAR;
    else it.func = rsr_pkg::FUNC_SPARE;
    k = $urandom_range(0, 9);
    if (k < 5) it.sample = 16'($urandom());
    else if (k < 8) it.sample = 16'($signed($urandom_range(0, 200)) - 100);
    else it.sample = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
    it.rand_fraction = $urandom();
    if ($urandom_range(0, 3) == 0 || eff == 0) it.read_slot = 7'($urandom_range(0, 127));
    else it.read_slot = 7'($urandom_range(0, eff - 1));
    return it;
  endfunction

  // result side
  always @(negedge clk) begin
    if (!hold_done && in_beats >= HOLD_AT_BEAT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    rsr_pkg::out_item_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: %h", $time, a);
      end else begin
        e = expected_results.pop_front();
        check_field("count", e.count, a.count);
        check_field("mean", e.mean, a.mean);
        check_field("variance", e.variance, a.variance);
        check_field("min_value", e.min_value, a.min_value);
        check_field("max_value", e.max_value, a.max_value);
        check_field("mean_valid", e.mean_valid, a.mean_valid);
        check_field("variance_valid", e.variance_valid, a.variance_valid);
        check_field("count_full", e.count_full, a.count_full);
        check_field("slot_value", e.slot_value, a.slot_value);
        check_field("slot_valid", e.slot_valid, a.slot_valid);
        check_field("sample_kept", e.sample_kept, a.sample_kept);
        check_field("kept_slot", e.kept_slot, a.kept_slot);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rsr_pkg::in_item_t  dir_in [DIR_ROWS];
    rsr_pkg::out_item_t dir_fixed [DIR_ROWS];
    bit                 dir_typed [DIR_ROWS];
    rsr_pkg::in_item_t  it;
    rsr_pkg::out_item_t none;
    logic [7:0] sizes [7];
    int unsigned eff;
    shortint    pmax, pmin;
    pmax = 16'sh7fff;
    pmin = -16'sh8000;
    none = '0;
    sizes = '{8'd1, 8'd128, 8'd255, 8'd0, 8'd7, 8'd100, 8'd3};

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_size = rsr_pkg::DEFAULT_RES_SIZE;
    clear_stats();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: func, sample, rand fraction, read slot
    dir_in = '{
      '{rsr_pkg::FUNC_QUERY, 16'sd0, 32'd0, 7'd0},
      '{rsr_pkg::FUNC_SPARE, 16'sd0, 32'hffffffff, 7'd127},
      '{rsr_pkg::FUNC_CLEAR, 16'sd0, 32'd0, 7'd0},
      '{rsr_pkg::FUNC_ADD, 16'sh7fff, 32'd0, 7'd0},
      '{rsr_pkg::FUNC_ADD, -16'sh8000, 32'hffffffff, 7'd1},
      '{rsr_pkg::FUNC_ADD, 16'sd0, 32'd0, 7'd2},
      '{rsr_pkg::FUNC_ADD, -16'sd1, 32'h80000000, 7'd127},
      '{rsr_pkg::FUNC_ADD, 16'sd1, 32'd0, 7'd3},
      '{rsr_pkg::FUNC_QUERY, 16'sd0, 32'd0, 7'd5},
      '{rsr_pkg::FUNC_SPARE, 16'sh7fff, 32'd0, 7'd4},
      '{rsr_pkg::FUNC_ADD, 16'sh7fff, 32'd1, 7'd5},
      '{rsr_pkg::FUNC_ADD, -16'sh8000, 32'd2, 7'd6},
      '{rsr_pkg::FUNC_ADD, 16'sh7fff, 32'h7fffffff, 7'd7},
      '{rsr_pkg::FUNC_ADD, -16'sh8000, 32'hfffffffe, 7'd8},
      '{rsr_pkg::FUNC_QUERY, 16'sd0, 32'd0, 7'd100},
      '{rsr_pkg::FUNC_CLEAR, 16'sh1234, 32'd0, 7'd0},
      '{rsr_pkg::FUNC_QUERY, 16'sd0, 32'd0, 7'd0},
      '{rsr_pkg::FUNC_ADD, -16'sh8000, 32'd0, 7'd0},
      '{rsr_pkg::FUNC_ADD, -16'sh8000, 32'hffffffff, 7'd1},
      '{rsr_pkg::FUNC_QUERY, 16'sd0, 32'd0, 7'd1}
    };
    foreach (dir_in[i]) begin
      dir_typed[i] = 1'b0;
      dir_fixed[i] = none;
    end
    // rows whose result is plain from reset or clear
    dir_typed[0] = 1'b1; dir_fixed[0] = fixed_result(0, 0, pmax, pmin, 0, 0, 0);
    dir_typed[1] = 1'b1; dir_fixed[1] = fixed_result(0, 0, pmax, pmin, 0, 0, 0);
    dir_typed[2] = 1'b1; dir_fixed[2] = fixed_result(0, 0, pmax, pmin, 0, 0, 0);
    dir_typed[3] = 1'b1; dir_fixed[3] = fixed_result(1, 32'h7fff0000, pmax, pmax, pmax, 1, 1);
    dir_typed[15] = 1'b1; dir_fixed[15] = fixed_result(0, 0, pmax, pmin, 0, 0, 0);
    dir_typed[16] = 1'b1; dir_fixed[16] = fixed_result(0, 0, pmax, pmin, 0, 0, 0);
    dir_typed[17] = 1'b1; dir_fixed[17] = fixed_result(1, 32'h80000000, pmin, pmin, pmin, 1, 1);

    foreach (dir_in[i]) send_item(dir_in[i], dir_typed[i], dir_fixed[i]);

    // random phases, one reservoir size each
    foreach (sizes[p]) begin
      wait_drained();
      write_size(sizes[p]);
      eff = (sizes[p] > rsr_pkg::RES_DEPTH) ? rsr_pkg::RES_DEPTH : sizes[p];
      calm = (p == 1);
      repeat (155) begin
        it = random_item(eff);
        send_item(it, 1'b0, none);
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

[running_stats_reservoir.f]
rtl/rsr_pkg.sv
rtl/rsr_stream_if.sv
rtl/rsr_sdiv.sv
rtl/rsr_smul.sv
rtl/running_stats_reservoir.sv
verif/tb_top.sv
